// File: src/svf_pkg.sv
// Shared widths, codes and control structs of the trapezoidal state variable filter.
// No dependencies; every other file of the block imports this package.
package svf_pkg;

    // Data formats
    localparam int SAMPLE_W = 24;                    // Q1.23 samples
    localparam int STATE_W  = 32;                    // integrator states
    localparam int FRAC_W   = 30;                    // Q2.30 coefficient fraction
    localparam int COEF_W   = 32;                    // widest coefficient
    localparam int MODE_W   = 3;
    localparam int A1_W     = 31;
    localparam int A2_W     = 30;
    localparam int A3_W     = 31;

    // Shared multiplier widths
    localparam int MAG_W  = STATE_W + 1;             // operand magnitude
    localparam int PROD_W = MAG_W + COEF_W;          // full product
    localparam int TERM_W = PROD_W - FRAC_W + 1;     // rounded signed term
    localparam int ACC_W  = TERM_W + 2;              // accumulator and output sums

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A3   = 3'd4;

    // Filter response codes
    localparam logic [MODE_W-1:0] MODE_LP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NOTCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEAK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AP    = 3'd5;

    // Multiplier operand selects
    localparam logic [1:0] OPD_BAND = 2'd0;
    localparam logic [1:0] OPD_V3   = 2'd1;
    localparam logic [1:0] OPD_V1   = 2'd2;

    // Multiplier coefficient selects
    localparam logic [1:0] CF_A1 = 2'd0;
    localparam logic [1:0] CF_A2 = 2'd1;
    localparam logic [1:0] CF_A3 = 2'd2;
    localparam logic [1:0] CF_K  = 2'd3;

    // Accumulator operations
    localparam logic [2:0] ACC_NONE    = 3'd0;
    localparam logic [2:0] ACC_LD_TERM = 3'd1;   // acc = term
    localparam logic [2:0] ACC_V1      = 3'd2;   // v1 = sat(acc + term)
    localparam logic [2:0] ACC_LD_LOW  = 3'd3;   // acc = low + term
    localparam logic [2:0] ACC_V2      = 3'd4;   // v2 = sat(acc + term)

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COEF_W-1:0] k;
        logic [A1_W-1:0]   a1;
        logic [A2_W-1:0]   a2;
        logic [A3_W-1:0]   a3;
    } t_cfg;

    typedef struct packed {
        logic       ld_x;      // capture a sample word
        logic       clr_st;    // zero both integrators
        logic       ld_v3;     // form v3 = x - low
        logic       issue;     // load a new multiplier operand pair
        logic [1:0] opd_sel;
        logic [1:0] cf_sel;
        logic [2:0] acc_op;
        logic       commit;    // update integrators and write the result word
    } t_cmd;

    typedef struct packed {
        logic out_free;        // result register can take a word this cycle
    } t_sts;

endpackage

// File: src/svf_if.sv
// Stream and configuration channel interfaces of the state variable filter.
// Depends on svf_pkg for field widths.

interface svf_smp_if;
    import svf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       clear;
    modport source (output valid, output sample_in, output clear, input ready);
    modport sink   (input valid, input sample_in, input clear, output ready);
endinterface

interface svf_res_if;
    import svf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface svf_cfg_if;
    import svf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/svf_regs.sv
// Configuration register file: filter mode, damping and the three coefficients.
// Depends on svf_pkg.
module svf_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [svf_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [svf_pkg::CFG_DATA_W-1:0] i_data,
    output logic                           o_ready,
    output svf_pkg::t_cfg                  o_cfg
);
    import svf_pkg::*;

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Decode the index and keep each register at its own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_valid) begin
            unique case (i_index)
                REG_MODE: r_cfg.mode <= i_data[MODE_W-1:0];
                REG_K:    r_cfg.k    <= i_data[COEF_W-1:0];
                REG_A1:   r_cfg.a1   <= i_data[A1_W-1:0];
                REG_A2:   r_cfg.a2   <= i_data[A2_W-1:0];
                REG_A3:   r_cfg.a3   <= i_data[A3_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/svf_ctrl.sv
// Sequencer of the state variable filter: steps one sample through the shared
// multiplier and accumulator. Depends on svf_pkg for the command and status structs.
module svf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_clear,
    output logic          o_in_ready,
    input  svf_pkg::t_sts i_sts,
    output svf_pkg::t_cmd o_cmd
);
    import svf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P1   = 4'd1;
    localparam logic [3:0] ST_P2   = 4'd2;
    localparam logic [3:0] ST_P3   = 4'd3;
    localparam logic [3:0] ST_P4   = 4'd4;
    localparam logic [3:0] ST_P5   = 4'd5;
    localparam logic [3:0] ST_P6   = 4'd6;
    localparam logic [3:0] ST_P7   = 4'd7;
    localparam logic [3:0] ST_P8   = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Issue order: a1*b, a2*v3, a2*b, a3*v3, then k*v1; each term is used once it has passed r_mag, r_prod and r_term
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ld_x   = w_accept && !i_in_clear;
                o_cmd.clr_st = w_accept && i_in_clear;
                if (w_accept && !i_in_clear) n_state = ST_P1;
            end
            ST_P1: begin
                o_cmd.ld_v3   = 1'b1;
                o_cmd.issue   = 1'b1;
                o_cmd.opd_sel = OPD_BAND;
                o_cmd.cf_sel  = CF_A1;
                n_state       = ST_P2;
            end
            ST_P2: begin
                o_cmd.issue   = 1'b1;
                o_cmd.opd_sel = OPD_V3;
                o_cmd.cf_sel  = CF_A2;
                n_state       = ST_P3;
            end
            ST_P3: begin
                o_cmd.issue   = 1'b1;
                o_cmd.opd_sel = OPD_BAND;
                o_cmd.cf_sel  = CF_A2;
                n_state       = ST_P4;
            end
            ST_P4: begin
                o_cmd.issue   = 1'b1;
                o_cmd.opd_sel = OPD_V3;
                o_cmd.cf_sel  = CF_A3;
                o_cmd.acc_op  = ACC_LD_TERM;
                n_state       = ST_P5;
            end
            ST_P5: begin
                o_cmd.acc_op = ACC_V1;
                n_state      = ST_P6;
            end
            ST_P6: begin
                o_cmd.issue   = 1'b1;
                o_cmd.opd_sel = OPD_V1;
                o_cmd.cf_sel  = CF_K;
                o_cmd.acc_op  = ACC_LD_LOW;
                n_state       = ST_P7;
            end
            ST_P7: begin
                o_cmd.acc_op = ACC_V2;
                n_state      = ST_P8;
            end
            ST_P8: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // Hold here while the previous result word is still waiting
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/svf_dp.sv
// Datapath of the state variable filter: integrators, shared rounding multiplier,
// accumulator, response select and result register. Depends on svf_pkg.
module svf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  svf_pkg::t_cfg                      i_cfg,
    input  svf_pkg::t_cmd                      i_cmd,
    output svf_pkg::t_sts                      o_sts,
    input  logic signed [svf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [svf_pkg::SAMPLE_W-1:0] o_sample
);
    import svf_pkg::*;

    localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

    // Clamp a wide sum to the state range
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1]);
        if (fits) return v[STATE_W-1:0];
        return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    // Clamp a wide sum to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:SAMPLE_W-1]) || !(|v[ACC_W-1:SAMPLE_W-1]);
        if (fits) return v[SAMPLE_W-1:0];
        return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_state(input logic signed [STATE_W-1:0] v);
        return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_sample(input logic signed [SAMPLE_W-1:0] v);
        return {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // Filter state and per-sample values
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [STATE_W-1:0]  r_band;
    logic signed [STATE_W-1:0]  r_low;
    logic signed [MAG_W-1:0]    r_v3;
    logic signed [STATE_W-1:0]  r_v1;
    logic signed [STATE_W-1:0]  r_v2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_last;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_valid;

    // Multiplier pipeline
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [COEF_W-1:0]        r_coef;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_pneg;
    logic signed [TERM_W-1:0] r_term;

    logic signed [MAG_W-1:0]  w_opd;
    logic [MAG_W-1:0]         w_opd_u;
    logic [MAG_W-1:0]         n_mag;
    logic [COEF_W-1:0]        n_coef;
    logic [PROD_W:0]          w_rsum;
    logic [TERM_W-1:0]        w_rnd;
    logic signed [TERM_W-1:0] n_term;
    logic signed [ACC_W-1:0]  w_term_a;
    logic signed [ACC_W-1:0]  w_x_a;
    logic signed [ACC_W-1:0]  w_v1_a;
    logic signed [ACC_W-1:0]  w_v2_a;
    logic signed [ACC_W-1:0]  w_y;
    logic signed [SAMPLE_W-1:0] n_y;
    logic signed [STATE_W-1:0]  n_band;
    logic signed [STATE_W-1:0]  n_low;
    logic signed [MAG_W-1:0]    n_v3;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out;

    // Select operand and coefficient, take the magnitude
    always_comb begin
        unique case (i_cmd.opd_sel)
            OPD_BAND: w_opd = {r_band[STATE_W-1], r_band};
            OPD_V3:   w_opd = r_v3;
            OPD_V1:   w_opd = {r_v1[STATE_W-1], r_v1};
            default:  w_opd = '0;
        endcase
        unique case (i_cmd.cf_sel)
            CF_A1:   n_coef = {{(COEF_W-A1_W){1'b0}}, i_cfg.a1};
            CF_A2:   n_coef = {{(COEF_W-A2_W){1'b0}}, i_cfg.a2};
            CF_A3:   n_coef = {{(COEF_W-A3_W){1'b0}}, i_cfg.a3};
            CF_K:    n_coef = i_cfg.k;
            default: n_coef = '0;
        endcase
        w_opd_u = w_opd;
        n_mag   = w_opd[MAG_W-1] ? (~w_opd_u + 1'b1) : w_opd_u;
    end

    // Round to nearest with ties away from zero on the magnitude, then restore sign
    assign w_rsum = {1'b0, r_prod} + RND_HALF;
    assign w_rnd  = {1'b0, w_rsum[PROD_W-1:FRAC_W]};
    assign n_term = r_pneg ? -$signed(w_rnd) : $signed(w_rnd);

    assign w_term_a = {{(ACC_W-TERM_W){r_term[TERM_W-1]}}, r_term};
    assign w_x_a    = ext_sample(r_x);
    assign w_v1_a   = ext_state(r_v1);
    assign w_v2_a   = ext_state(r_v2);
    assign n_v3     = {{(MAG_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x} - {r_low[STATE_W-1], r_low};

    // Response select; the last term holds k*v1 at commit
    always_comb begin
        unique case (i_cfg.mode)
            MODE_LP:    w_y = w_v2_a;
            MODE_BP:    w_y = w_v1_a;
            MODE_HP:    w_y = w_x_a - w_term_a - w_v2_a;
            MODE_NOTCH: w_y = w_x_a - w_term_a;
            MODE_PEAK:  w_y = (w_v2_a <<< 1) - w_x_a + w_term_a;
            MODE_AP:    w_y = w_x_a - (w_term_a <<< 1);
            default:    w_y = ext_sample(r_last);
        endcase
        n_y    = sat_sample(w_y);
        n_band = sat_state((w_v1_a <<< 1) - ext_state(r_band));
        n_low  = sat_state((w_v2_a <<< 1) - ext_state(r_low));
    end

    // Advance the multiplier stages; operands load only on issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_mag  <= n_mag;
            r_neg  <= w_opd[MAG_W-1];
            r_coef <= n_coef;
        end
        r_prod <= r_mag * r_coef;
        r_pneg <= r_neg;
        r_term <= n_term;
    end

    // Capture the sample, form v3, accumulate v1 and v2
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x) r_x <= i_sample;
        if (i_cmd.ld_v3) r_v3 <= n_v3;
        unique case (i_cmd.acc_op)
            ACC_LD_TERM: r_acc <= w_term_a;
            ACC_V1:      r_v1  <= sat_state(r_acc + w_term_a);
            ACC_LD_LOW:  r_acc <= ext_state(r_low) + w_term_a;
            ACC_V2:      r_v2  <= sat_state(r_acc + w_term_a);
            default: begin
            end
        endcase
    end

    // Integrators, last result and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band      <= '0;
            r_low       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_st) begin
                r_band <= '0;
                r_low  <= '0;
            end else if (i_cmd.commit) begin
                r_band <= n_band;
                r_low  <= n_low;
            end
            if (i_cmd.commit) begin
                r_last      <= n_y;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= n_y;
    end

endmodule

// File: src/trapezoidal_state_variable_filter_core.sv
// Top level of the trapezoidal state variable filter: channels, configuration
// registers, sequencer and datapath. Depends on svf_pkg, svf_if, svf_regs, svf_ctrl, svf_dp.
//
//   channel   dir   payload                       word taken when
//   i_smp     in    sample_in[23:0], clear        valid && ready
//   o_res     out   sample_out[23:0]              valid && ready
//   i_cfg     in    index[2:0], data[31:0]        valid && ready (ready always high)
//
// A sample word is accepted in the idle state; steps P1 to P8 and a final commit step
// feed five products through the one shared multiplier (select, multiply, round,
// accumulate stages). A clear word zeroes both integrators and gives no result.
// Synchronous active-low reset zeroes the configuration registers and both integrators; no sweep.
// A waiting result word stalls only the final step of the next sample.
module trapezoidal_state_variable_filter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svf_smp_if.sink   i_smp,
    svf_res_if.source o_res,
    svf_cfg_if.sink   i_cfg
);
    import svf_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    svf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (w_cfg)
    );

    svf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_in_clear (i_smp.clear),
        .o_in_ready (i_smp.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    svf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_smp.sample_in),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_sample    (o_res.sample_out)
    );

`ifndef ASSERT_OFF
    // Never overwrite a result word that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten while waiting");

    // Multiplier issue and commit happen only while a sample is in flight
    a_busy_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.issue || w_cmd.commit || w_cmd.ld_v3) |-> !i_smp.ready)
        else $error("sequencer step while idle");

    // A clear word gives no result
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready && i_smp.clear) |=> !$rose(o_res.valid))
        else $error("result after clear word");

    // A sample word is never taken while the last one is being committed: no issue directly follows a commit
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> !w_cmd.issue)
        else $error("new sample started during commit");
`endif

endmodule
